@@ hdl/ffra_pkg.sv @@
// Shared types and codes for the first-fit region allocator.
// No dependencies.
package ffra_pkg;

   localparam int OP_ALLOC = 0;
   localparam int OP_FREE  = 1;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD       = 3'd1;
   localparam logic [2:0] ST_NOTALLOC  = 3'd2;
   localparam logic [2:0] ST_EXHAUSTED = 3'd3;
   localparam logic [2:0] ST_LISTFULL  = 3'd4;

   typedef struct packed {
      logic        operation;
      logic [7:0]  region_id;
      logic [31:0] byte_count;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] address;
   } rsp_payload_type;

endpackage

@@ hdl/first_fit_region_allocator.sv @@
// First-fit region allocator: region table and sorted free list in on-chip memories.
// Depends on ffra_pkg.
//
//   channel | ports                          | moves
//   --------+--------------------------------+-------------------------------
//   req     | req_valid req_ready req_payload| alloc or free request
//   rsp     | rsp_valid rsp_ready rsp_payload| status and start address
//   csr     | csr_valid csr_ready csr_wdata  | initial break pointer
//
// One request at a time. A request is checked, then free-list entries are scanned
// one by one, and entries are moved when the list shrinks or grows (the single
// free-list memory port does one read and one write a cycle).
// Reset clears the region table at once through per-ID valid bits; no sweep.
// A finished response waits in the output register; a new request is taken
// meanwhile, and it stalls only at its own end if rsp_ready is low.
module first_fit_region_allocator
   import ffra_pkg::*;
#(
   parameter int ID_SLOTS   = 32,
   parameter int FREE_SLOTS = 32,
   parameter int ADDR_BITS  = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [31:0]     csr_wdata
);

   localparam int AB     = ADDR_BITS;
   localparam int WW     = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 1;
   localparam int CNT_W  = $clog2(FREE_SLOTS + 1);
   localparam int FIDX_W = $clog2(FREE_SLOTS);
   localparam int RIDX_W = $clog2(ID_SLOTS);
   localparam logic [AB-1:0] ADDR_MASK = {AB{1'b1}};

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_CHK   = 11'b00000000010,
      S_A_RD  = 11'b00000000100,
      S_A_CHK = 11'b00000001000,
      S_F_RD  = 11'b00000010000,
      S_F_CHK = 11'b00000100000,
      S_F_DEC = 11'b00001000000,
      S_MV_RD = 11'b00010000000,
      S_MV_WR = 11'b00100000000,
      S_FIN   = 11'b01000000000,
      S_RESP  = 11'b10000000000
   } state_type;

   state_type            state_ff, state_in;
   req_payload_type      req_ff, req_in;
   logic [CNT_W-1:0]     i_ff, i_in, a_ff, a_in, b_ff, b_in, cnt_ff, cnt_in;
   logic [CNT_W-1:0]     mv_src_ff, mv_src_in, mv_end_ff, mv_end_in, mv_dist_ff, mv_dist_in;
   logic                 mv_up_ff, mv_up_in, merged_ff, merged_in;
   logic [AB-1:0]        s_ff, s_in, e_ff, e_in, ns_ff, ns_in, ne_ff, ne_in, bp_ff, bp_in;
   logic [ID_SLOTS-1:0]  rv_ff, rv_in;
   logic [2:0]           st_ff, st_in;
   logic [31:0]          addr_ff, addr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_ff, rsp_in;

   logic [2*AB-1:0]      fm [FREE_SLOTS];
   logic [2*AB-1:0]      rm [ID_SLOTS];
   logic [2*AB-1:0]      fq_ff, rq_ff;
   logic                 fm_we, rm_we;
   logic [FIDX_W-1:0]    fm_waddr, fm_raddr;
   logic [2*AB-1:0]      fm_wdata, rm_wdata;
   logic [RIDX_W-1:0]    rm_idx;

   logic [AB-1:0]        fq_s, fq_e;
   logic [WW-1:0]        size_w, span_w;
   logic [AB-1:0]        fit_end, brk_end;
   logic                 id_bad;
   logic [CNT_W-1:0]     gone;

   assign fq_s    = fq_ff[2*AB-1:AB];
   assign fq_e    = fq_ff[AB-1:0];
   assign size_w  = WW'(req_ff.byte_count);
   assign span_w  = WW'(fq_e - fq_s);
   assign fit_end = AB'(WW'(fq_s) + size_w);
   assign brk_end = AB'(WW'(bp_ff) + size_w);
   assign id_bad  = (9'(req_ff.region_id) >= 9'(ID_SLOTS));
   assign rm_idx  = (state_ff == S_IDLE) ? req_payload.region_id[RIDX_W-1:0]
                                         : req_ff.region_id[RIDX_W-1:0];
   assign gone    = b_ff - a_ff - CNT_W'(1);

   assign req_ready   = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      i_in         = i_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      cnt_in       = cnt_ff;
      mv_src_in    = mv_src_ff;
      mv_end_in    = mv_end_ff;
      mv_dist_in   = mv_dist_ff;
      mv_up_in     = mv_up_ff;
      merged_in    = merged_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      ns_in        = ns_ff;
      ne_in        = ne_ff;
      bp_in        = bp_ff;
      rv_in        = rv_ff;
      st_in        = st_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      fm_we        = 1'b0;
      fm_waddr     = '0;
      fm_wdata     = '0;
      fm_raddr     = '0;
      rm_we        = 1'b0;
      rm_wdata     = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            st_in   = ST_OK;
            addr_in = '0;
            i_in    = '0;
            if (id_bad || (req_ff.operation == 1'(OP_ALLOC) && req_ff.byte_count == '0)) begin
               st_in    = ST_BAD;
               state_in = S_RESP;
            end else if (req_ff.operation == 1'(OP_ALLOC)) begin
               state_in = S_A_RD;
            end else if (!rv_ff[req_ff.region_id[RIDX_W-1:0]]) begin
               st_in    = ST_NOTALLOC;
               state_in = S_RESP;
            end else if (rq_ff[2*AB-1:AB] >= rq_ff[AB-1:0]) begin
               rv_in[req_ff.region_id[RIDX_W-1:0]] = 1'b0;
               state_in = S_RESP;
            end else begin
               s_in      = rq_ff[2*AB-1:AB];
               e_in      = rq_ff[AB-1:0];
               ns_in     = rq_ff[2*AB-1:AB];
               ne_in     = rq_ff[AB-1:0];
               a_in      = '0;
               b_in      = '0;
               merged_in = 1'b0;
               state_in  = S_F_RD;
            end
         end
         S_A_RD: begin
            if (i_ff >= cnt_ff) begin
               // no free range fits: place at the break
               if (size_w > WW'(ADDR_MASK - bp_ff)) begin
                  st_in = ST_EXHAUSTED;
               end else begin
                  rm_we    = 1'b1;
                  rm_wdata = {bp_ff, brk_end};
                  rv_in[req_ff.region_id[RIDX_W-1:0]] = 1'b1;
                  addr_in  = 32'(bp_ff);
                  bp_in    = brk_end;
               end
               state_in = S_RESP;
            end else begin
               fm_raddr = i_ff[FIDX_W-1:0];
               state_in = S_A_CHK;
            end
         end
         S_A_CHK: begin
            if (size_w <= span_w) begin
               rm_we    = 1'b1;
               rm_wdata = {fq_s, fit_end};
               rv_in[req_ff.region_id[RIDX_W-1:0]] = 1'b1;
               addr_in  = 32'(fq_s);
               if (size_w == span_w) begin
                  cnt_in = cnt_ff - CNT_W'(1);
                  if (i_ff + CNT_W'(1) < cnt_ff) begin
                     mv_src_in  = i_ff + CNT_W'(1);
                     mv_end_in  = cnt_ff;
                     mv_dist_in = CNT_W'(1);
                     mv_up_in   = 1'b0;
                     state_in   = S_MV_RD;
                  end else begin
                     state_in = S_RESP;
                  end
               end else begin
                  fm_we    = 1'b1;
                  fm_waddr = i_ff[FIDX_W-1:0];
                  fm_wdata = {fit_end, fq_e};
                  state_in = S_RESP;
               end
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = S_A_RD;
            end
         end
         S_F_RD: begin
            if (i_ff >= cnt_ff) begin
               state_in = S_F_DEC;
            end else begin
               fm_raddr = i_ff[FIDX_W-1:0];
               state_in = S_F_CHK;
            end
         end
         S_F_CHK: begin
            if (fq_e < s_ff) begin
               a_in     = i_ff + CNT_W'(1);
               i_in     = i_ff + CNT_W'(1);
               state_in = S_F_RD;
            end else if (fq_s <= e_ff) begin
               if (!merged_ff) begin
                  ns_in = (fq_s < s_ff) ? fq_s : s_ff;
               end
               merged_in = 1'b1;
               ne_in     = (fq_e > ne_ff) ? fq_e : ne_ff;
               b_in      = i_ff + CNT_W'(1);
               i_in      = i_ff + CNT_W'(1);
               state_in  = S_F_RD;
            end else begin
               state_in = S_F_DEC;
            end
         end
         S_F_DEC: begin
            if (merged_ff) begin
               fm_we    = 1'b1;
               fm_waddr = a_ff[FIDX_W-1:0];
               fm_wdata = {ns_ff, ne_ff};
               rv_in[req_ff.region_id[RIDX_W-1:0]] = 1'b0;
               cnt_in   = cnt_ff - gone;
               if (b_ff < cnt_ff && gone != '0) begin
                  mv_src_in  = b_ff;
                  mv_end_in  = cnt_ff;
                  mv_dist_in = gone;
                  mv_up_in   = 1'b0;
                  state_in   = S_MV_RD;
               end else begin
                  state_in = S_RESP;
               end
            end else if (cnt_ff >= CNT_W'(FREE_SLOTS)) begin
               st_in    = ST_LISTFULL;
               state_in = S_RESP;
            end else if (cnt_ff > a_ff) begin
               // open a hole at the insert point, moving from the top down
               mv_src_in  = cnt_ff - CNT_W'(1);
               mv_end_in  = a_ff;
               mv_dist_in = CNT_W'(1);
               mv_up_in   = 1'b1;
               state_in   = S_MV_RD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_MV_RD: begin
            fm_raddr = mv_src_ff[FIDX_W-1:0];
            state_in = S_MV_WR;
         end
         S_MV_WR: begin
            fm_we    = 1'b1;
            fm_wdata = fq_ff;
            if (mv_up_ff) begin
               fm_waddr = FIDX_W'(mv_src_ff + mv_dist_ff);
               if (mv_src_ff == mv_end_ff) begin
                  state_in = S_FIN;
               end else begin
                  mv_src_in = mv_src_ff - CNT_W'(1);
                  state_in  = S_MV_RD;
               end
            end else begin
               fm_waddr = FIDX_W'(mv_src_ff - mv_dist_ff);
               if (mv_src_ff + CNT_W'(1) == mv_end_ff) begin
                  state_in = S_RESP;
               end else begin
                  mv_src_in = mv_src_ff + CNT_W'(1);
                  state_in  = S_MV_RD;
               end
            end
         end
         S_FIN: begin
            fm_we    = 1'b1;
            fm_waddr = a_ff[FIDX_W-1:0];
            fm_wdata = {s_ff, e_ff};
            cnt_in   = cnt_ff + CNT_W'(1);
            rv_in[req_ff.region_id[RIDX_W-1:0]] = 1'b0;
            state_in = S_RESP;
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_in.status  = st_ff;
               rsp_in.address = addr_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_valid) begin
         bp_in = AB'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (fm_we) begin
         fm[fm_waddr] <= fm_wdata;
      end
      fq_ff <= fm[fm_raddr];
      if (rm_we) begin
         rm[req_ff.region_id[RIDX_W-1:0]] <= rm_wdata;
      end
      rq_ff <= rm[rm_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         bp_ff        <= '0;
         rv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         bp_ff        <= bp_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff     <= req_in;
      i_ff       <= i_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      mv_src_ff  <= mv_src_in;
      mv_end_ff  <= mv_end_in;
      mv_dist_ff <= mv_dist_in;
      mv_up_ff   <= mv_up_in;
      merged_ff  <= merged_in;
      s_ff       <= s_in;
      e_ff       <= e_in;
      ns_ff      <= ns_in;
      ne_ff      <= ne_in;
      st_ff      <= st_in;
      addr_ff    <= addr_in;
      rsp_ff     <= rsp_in;
   end

endmodule

@@ sim/first_fit_region_allocator_tb.sv @@
// Testbench for first_fit_region_allocator: self-checking against a behavioral
// allocator predictor, with random sender bursts and receiver stalls.
// Depends on ffra_pkg and the allocator RTL.
module first_fit_region_allocator_tb;
   import ffra_pkg::*;

   localparam int NUM_IDS    = 32;
   localparam int NUM_FREE   = 32;
   localparam int IDLE_LIMIT = 20000;
   localparam logic [32:0] ADDR_TOP = 33'h0_FFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [31:0] csr_wdata = '0;

   first_fit_region_allocator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state, 33-bit addresses so wrap checks are exact
   logic [32:0] region_lo [NUM_IDS];
   logic [32:0] region_hi [NUM_IDS];
   logic [32:0] hole_lo [$];
   logic [32:0] hole_hi [$];
   logic [32:0] brk;

   req_payload_type pending_requests [$];
   rsp_payload_type expected_responses [$];
   int errors = 0;
   int accepted_requests = 0;
   int checked_responses = 0;
   int idle_cycles = 0;
   int gap_left = 0;
   int burst_left = 0;
   bit hold_sender = 1'b0;
   int status_seen [5];

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("ERROR response %0d %s: got %h expected %h", checked_responses, what, got,
               want);
   endtask

   function automatic void clear_model(input logic [31:0] start_break);
      for (int i = 0; i < NUM_IDS; i++) begin
         region_lo[i] = '0;
         region_hi[i] = '0;
      end
      hole_lo.delete();
      hole_hi.delete();
      brk = {1'b0, start_break};
   endfunction

   function automatic rsp_payload_type allocate_region(input logic [7:0] id,
                                                     input logic [31:0] size);
      rsp_payload_type r;
      logic [32:0] sz;
      r = '0;
      sz = {1'b0, size};
      if (id >= NUM_IDS || size == 0) begin
         r.status = ST_BAD;
         return r;
      end
      for (int i = 0; i < hole_lo.size(); i++) begin
         if (sz <= hole_hi[i] - hole_lo[i]) begin
            region_lo[id] = hole_lo[i];
            region_hi[id] = hole_lo[i] + sz;
            r.address = hole_lo[i][31:0];
            if (sz == hole_hi[i] - hole_lo[i]) begin
               hole_lo.delete(i);
               hole_hi.delete(i);
            end else begin
               hole_lo[i] = hole_lo[i] + sz;
            end
            r.status = ST_OK;
            return r;
         end
      end
      if (sz > ADDR_TOP - brk) begin
         r.status = ST_EXHAUSTED;
         return r;
      end
      region_lo[id] = brk;
      region_hi[id] = brk + sz;
      r.address = brk[31:0];
      brk = brk + sz;
      r.status = ST_OK;
      return r;
   endfunction

   function automatic rsp_payload_type release_region(input logic [7:0] id);
      rsp_payload_type r;
      logic [32:0] s, e, ns, ne;
      int a, b;
      r = '0;
      if (id >= NUM_IDS) begin
         r.status = ST_BAD;
         return r;
      end
      s = region_lo[id];
      e = region_hi[id];
      if (s == 0 && e == 0) begin
         r.status = ST_NOTALLOC;
         return r;
      end
      if (s < e) begin
         a = 0;
         while (a < hole_lo.size() && hole_hi[a] < s) a++;
         b = a;
         while (b < hole_lo.size() && hole_lo[b] <= e) b++;
         if (b > a) begin
            ns = hole_lo[a] < s ? hole_lo[a] : s;
            ne = hole_hi[b-1] > e ? hole_hi[b-1] : e;
            hole_lo[a] = ns;
            hole_hi[a] = ne;
            for (int k = 0; k < b - a - 1; k++) begin
               hole_lo.delete(a + 1);
               hole_hi.delete(a + 1);
            end
         end else begin
            if (hole_lo.size() >= NUM_FREE) begin
               r.status = ST_LISTFULL;
               return r;
            end
            hole_lo.insert(a, s);
            hole_hi.insert(a, e);
         end
      end
      region_lo[id] = '0;
      region_hi[id] = '0;
      r.status = ST_OK;
      return r;
   endfunction

   function automatic rsp_payload_type predict_response(input req_payload_type q);
      if (q.operation == OP_ALLOC[0]) return allocate_region(q.region_id, q.byte_count);
      return release_region(q.region_id);
   endfunction

   function automatic req_payload_type make_request(input bit op, input int id,
                                                  input logic [31:0] size);
      req_payload_type q;
      q.operation = op;
      q.region_id = id[7:0];
      q.byte_count = size;
      return q;
   endfunction

   // driver: bursts of requests with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
         // hold until accepted
      end else begin
         if (req_valid) begin
            expected_responses.push_back(predict_response(req_payload));
            accepted_requests++;
         end
         if (burst_left == 0) begin
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
         if (!hold_sender && pending_requests.size() > 0 && burst_left > 0) begin
            req_payload <= pending_requests.pop_front();
            req_valid <= 1'b1;
            burst_left--;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor plus receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               report("unexpected response", rsp_payload.address, '0);
            end else begin
               rsp_payload_type w;
               w = expected_responses.pop_front();
               status_seen[w.status < 5 ? w.status : 0]++;
               if (rsp_payload.status !== w.status)
                  report("status", rsp_payload.status, w.status);
               if (rsp_payload.address !== w.address)
                  report("address", rsp_payload.address, w.address);
            end
            checked_responses++;
         end
         case ((accepted_requests / 64) % 3)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 9) < 3);
         endcase
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("ERROR timeout with %0d responses outstanding", expected_responses.size());
         $display("first_fit_region_allocator: mismatch");
         $finish;
      end
   end

   task automatic drain();
      while (pending_requests.size() > 0 || req_valid || expected_responses.size() > 0)
         @(posedge clock);
      repeat (4 * NUM_FREE + 20) @(posedge clock);
   endtask

   // break write reloads only the break; the tables are kept
   function automatic void clear_model_break(input logic [31:0] value);
      brk = {1'b0, value};
   endfunction

   task automatic write_break(input logic [31:0] value);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      clear_model_break(value);
   endtask

   task automatic random_phase(input int count, input int size_max);
      for (int n = 0; n < count; n++) begin
         int pick;
         logic [31:0] sz;
         pick = $urandom_range(0, 99);
         sz = $urandom_range(1, size_max);
         if (pick < 3) sz = $urandom();
         else if (pick < 5) sz = 0;
         if (pick < 50)
            pending_requests.push_back(make_request(OP_ALLOC[0],
               ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 31),
               sz));
         else
            pending_requests.push_back(make_request(OP_FREE[0],
               ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 31),
               $urandom()));
      end
   endtask

   initial begin
      clear_model(32'h0);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: break at reset value, bad ids, zero size, exact fit, merges
      pending_requests.push_back(make_request(OP_ALLOC[0], 0, 32'h10));
      pending_requests.push_back(make_request(OP_ALLOC[0], 1, 32'h20));
      pending_requests.push_back(make_request(OP_ALLOC[0], 2, 32'h30));
      pending_requests.push_back(make_request(OP_ALLOC[0], 3, 32'h0));
      pending_requests.push_back(make_request(OP_ALLOC[0], 255, 32'hFFFF_FFFF));
      pending_requests.push_back(make_request(OP_ALLOC[0], 32, 32'h1));
      pending_requests.push_back(make_request(OP_FREE[0], 255, 32'h0));
      pending_requests.push_back(make_request(OP_FREE[0], 5, 32'hFFFF_FFFF));
      pending_requests.push_back(make_request(OP_FREE[0], 0, 32'h0));
      pending_requests.push_back(make_request(OP_FREE[0], 2, 32'h0));
      pending_requests.push_back(make_request(OP_FREE[0], 1, 32'h0));
      pending_requests.push_back(make_request(OP_ALLOC[0], 4, 32'h60));
      pending_requests.push_back(make_request(OP_ALLOC[0], 4, 32'h8));
      pending_requests.push_back(make_request(OP_FREE[0], 4, 32'h0));
      pending_requests.push_back(make_request(OP_ALLOC[0], 31, 32'hFFFF_FFFF));
      pending_requests.push_back(make_request(OP_ALLOC[0], 31, 32'hFFFF_FF00));
      pending_requests.push_back(make_request(OP_ALLOC[0], 30, 32'h7FFF_FFFF));
      pending_requests.push_back(make_request(OP_FREE[0], 31, 32'h0));
      pending_requests.push_back(make_request(OP_FREE[0], 31, 32'h0));
      drain();

      // a run of small regions from a new break, then a random mix
      write_break(32'h0000_1000);
      for (int i = 0; i < 20; i++)
         pending_requests.push_back(make_request(OP_ALLOC[0], i, 32'h4));
      hold_sender = 1'b0;
      random_phase(120, 64);
      drain();

      // pause mid-stream until everything is answered, then resume
      write_break(32'hFFFF_FF80);
      random_phase(100, 48);
      repeat (300) @(posedge clock);
      hold_sender = 1'b1;
      while (req_valid || expected_responses.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      hold_sender = 1'b0;
      drain();

      write_break(32'hFFFF_FFFF);
      random_phase(60, 16);
      drain();

      write_break($urandom());
      random_phase(150, 4096);
      drain();

      $display("Covered %0d requests, %0d responses: ok %0d bad %0d notalloc %0d",
               accepted_requests, checked_responses, status_seen[0], status_seen[1],
               status_seen[2]);
      $display("exhausted %0d, list full %0d, four break writes", status_seen[3],
               status_seen[4]);
      if (errors == 0)
         $display("first_fit_region_allocator: match");
      else
         $display("first_fit_region_allocator: mismatch");
      $finish;
   end

endmodule
